// ----- rtl/indexed_list_insert_erase_defines.svh -----
// Assertion macros for the indexed list insert/erase block.
// Included by the top level; depends on nothing else.
`ifndef INDEXED_LIST_INSERT_ERASE_DEFINES_SVH
`define INDEXED_LIST_INSERT_ERASE_DEFINES_SVH

`ifndef SYNTHESIS
// Checks a property on every rising clk edge outside reset.
`define ILIE_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("indexed list assertion failed");
// Checks that a condition never holds.
`define ILIE_ASSERT_NEVER(label, cond) \
    `ILIE_ASSERT(label, !(cond))
`else
`define ILIE_ASSERT(label, prop)
`define ILIE_ASSERT_NEVER(label, cond)
`endif

`endif

// ----- rtl/ilie_pkg.sv -----
// Shared types and constants for the indexed list insert/erase block.
// Used by ilie_cell and indexed_list_insert_erase; depends on nothing.
package ilie_pkg;

    // Width of a stored data word.
    localparam int WORD_W    = 32;
    // Width that holds any count or position up to the largest capacity.
    localparam int CNT_MAX_W = 7;
    // Width of a request position inside the store (sign bit dropped).
    localparam int POS_W     = 6;

    // Operation applied to every cell of the chain at once.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ERASE,
        CELL_ROTATE
    } cell_op_t;

    // Controller state.
    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

    // Control broadcast from the controller to the cell chain.
    typedef struct packed {
        cell_op_t                op;
        logic [POS_W-1:0]        pos;
        logic [CNT_MAX_W-1:0]    count;
        logic [WORD_W-1:0]       value;
    } cell_ctrl_t;

endpackage

// ----- rtl/indexed_list_insert_erase.sv -----
// Indexed list store with insert and erase at a position, built as a
// chain of storage cells. Uses ilie_pkg, ilie_cell and the defines header.
//
// The block holds an ordered list of up to CAPACITY 32-bit words in a row
// of cells. When a request word is taken, the insert or erase is applied
// to all cells at once in that cycle, each cell loading from its
// neighbor. The block then dumps the list, one result word per cycle
// while m_tready is high, starting at element zero, by rotating the
// occupied cells toward cell zero; after count rotations the list is back
// in place. The dump gives max(count, 1) result words, where count is the
// length after the request, and no new request is taken until the last
// result word of the dump has been accepted. An empty list gives a single
// result word with tuser low.
`include "indexed_list_insert_erase_defines.svh"

module indexed_list_insert_erase #(
    parameter int CAPACITY = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields from bit 0: position (7, signed), value (32), zero fill.
    input  logic [39:0] s_tdata,
    // Fields from bit 0: func (1).
    input  logic        s_tuser,
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // Fields from bit 0: accepted (1), length (6), element_index (5),
    // element_value (32), zero fill.
    output logic [47:0] m_tdata,
    // Fields from bit 0: has_element (1).
    output logic        m_tuser,
    output logic        m_tlast
);
    import ilie_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // Request fields.
    logic                 req_func;
    logic [6:0]           req_pos;
    logic [WORD_W-1:0]    req_value;
    logic                 req_take;
    logic [CNT_MAX_W-1:0] pos_ext;
    logic [CNT_MAX_W-1:0] cnt_ext;
    logic                 ins_ok;
    logic                 ers_ok;

    // Control state.
    state_t               state_reg;
    state_t               state_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    logic                 ok_reg;
    logic                 ok_next;

    // Dump signals.
    logic                 out_take;
    logic                 is_empty;
    logic                 is_last;
    cell_ctrl_t           ctrl;
    logic [WORD_W-1:0]    cell_data [CAPACITY];
    logic [WORD_W-1:0]    head_word;

    assign req_func  = s_tuser;
    assign req_pos   = s_tdata[6:0];
    assign req_value = s_tdata[38:7];
    assign req_take  = s_tvalid && s_tready;
    assign out_take  = m_tvalid && m_tready;

    // Range checks of the request against the current length.
    assign pos_ext = {1'b0, req_pos[5:0]};
    assign cnt_ext = CNT_MAX_W'(count_reg);
    assign ins_ok  = !req_pos[6] && (pos_ext <= cnt_ext)
                     && (cnt_ext < CNT_MAX_W'(CAPACITY));
    assign ers_ok  = !req_pos[6] && (pos_ext < cnt_ext);

    assign is_empty = (count_reg == '0);
    assign is_last  = is_empty || (CNT_W'(idx_reg) + 1'b1 == count_reg);

    // Next state, cell control and handshake.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        ok_next    = ok_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        ctrl.op    = CELL_HOLD;
        ctrl.pos   = req_pos[5:0];
        ctrl.count = cnt_ext;
        ctrl.value = req_value;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (req_take)
                begin
                    idx_next   = '0;
                    state_next = ST_DUMP;
                    if (!req_func)
                    begin
                        ok_next = ins_ok;
                        if (ins_ok)
                        begin
                            ctrl.op    = CELL_INSERT;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        ok_next = ers_ok;
                        if (ers_ok)
                        begin
                            ctrl.op    = CELL_ERASE;
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
            end
            ST_DUMP:
            begin
                m_tvalid = 1'b1;
                if (out_take)
                begin
                    if (!is_empty)
                    begin
                        ctrl.op = CELL_ROTATE;
                    end
                    idx_next = idx_reg + 1'b1;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            ok_reg    <= ok_next;
        end
    end

    // Chain of storage cells; cell zero is the chain head.
    assign head_word = cell_data[0];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [WORD_W-1:0] left_word;
        logic [WORD_W-1:0] right_word;

        if (i == 0)
        begin : g_first
            assign left_word = cell_data[i];
        end
        else
        begin : g_inner_left
            assign left_word = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_final
            assign right_word = cell_data[i];
        end
        else
        begin : g_inner_right
            assign right_word = cell_data[i+1];
        end

        ilie_cell #(
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .left_data  (left_word),
            .right_data (right_word),
            .head_data  (head_word),
            .data       (cell_data[i])
        );
    end

    // Result word: cell zero always holds the element being shown.
    assign m_tdata = {4'b0000,
                      (is_empty ? '0 : head_word),
                      5'(idx_reg),
                      6'(count_reg),
                      ok_reg};
    assign m_tuser = !is_empty;
    assign m_tlast = is_last;

    // Requests and results are never offered in the same cycle.
    `ILIE_ASSERT_NEVER(a_one_side, s_tready && m_tvalid)
    // The length never exceeds the capacity.
    `ILIE_ASSERT_NEVER(a_count_range, count_reg > CNT_W'(CAPACITY))
    // The block is ready for a new request right after the last result.
    `ILIE_ASSERT(a_ready_after_dump, (out_take && m_tlast) |=> s_tready)
    // An accepted insert grows the list by exactly one.
    `ILIE_ASSERT(a_insert_grows, (ctrl.op == CELL_INSERT) |=> count_reg == $past(count_reg) + 1'b1)

endmodule

// ----- rtl/ilie_cell.sv -----
// One storage cell of the list chain: holds one word and loads from its
// left or right neighbor, the new value or the chain head. Uses ilie_pkg.
module ilie_cell #(
    parameter int INDEX = 0
) (
    input  logic                     clk,
    input  ilie_pkg::cell_ctrl_t     ctrl,
    input  logic [ilie_pkg::WORD_W-1:0] left_data,
    input  logic [ilie_pkg::WORD_W-1:0] right_data,
    input  logic [ilie_pkg::WORD_W-1:0] head_data,
    output logic [ilie_pkg::WORD_W-1:0] data
);
    import ilie_pkg::*;

    localparam logic [CNT_MAX_W-1:0] MY_IDX  = CNT_MAX_W'(INDEX);
    localparam logic [CNT_MAX_W-1:0] MY_NEXT = CNT_MAX_W'(INDEX + 1);

    logic [WORD_W-1:0]    data_reg;
    logic [WORD_W-1:0]    data_next;
    logic [CNT_MAX_W-1:0] pos_ext;

    assign pos_ext = {1'b0, ctrl.pos};

    // Select what this cell holds after the cycle.
    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.op)
            CELL_HOLD:
            begin
                data_next = data_reg;
            end
            CELL_INSERT:
            begin
                // Cells above the insertion point shift up by one.
                if (MY_IDX > pos_ext)
                begin
                    data_next = left_data;
                end
                else if (MY_IDX == pos_ext)
                begin
                    data_next = ctrl.value;
                end
            end
            CELL_ERASE:
            begin
                // Cells from the erased point on shift down by one.
                if (MY_IDX >= pos_ext)
                begin
                    data_next = right_data;
                end
            end
            CELL_ROTATE:
            begin
                // The occupied part of the chain rotates toward cell zero.
                if (MY_NEXT < ctrl.count)
                begin
                    data_next = right_data;
                end
                else if (MY_NEXT == ctrl.count)
                begin
                    data_next = head_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // Payload register; needs no reset.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
